// ===== sv/tws_pkg.sv =====
// shared constants and types for the textured wall column shader
package tws_pkg;

  // field widths of the input and result items
  localparam int OP_W     = 1;
  localparam int COL_W    = 10;
  localparam int ROW_W    = 16;
  localparam int WALL_W   = 12;
  localparam int SCALED_W = 15;
  localparam int LINE_W   = 6;
  localparam int CLIP_W   = 6;
  localparam int IDX_W    = 6;
  localparam int TEXEL_W  = 16;
  localparam int PY_W     = 6;

  // operation codes
  localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OP_W-1:0] OP_DRAW  = 1'b1;

  // texture and screen geometry
  localparam int unsigned TEX_SIZE_DEF = 64;
  localparam int          SCREEN_ROWS  = 64;

  // fixed point walk and lighting
  localparam int FRAC_W    = 16;
  localparam int POS_W     = 32;
  localparam int STEP_W    = WALL_W + FRAC_W;
  localparam int LQ_W      = 5;
  localparam int LIGHT_W   = 6;
  localparam int LIGHT_MAX = 32;

  // item held between the texel read and the output register
  typedef struct packed {
    logic [COL_W-1:0]   col;
    logic [PY_W-1:0]    y;
    logic               last;
    logic               line_ok;
    logic [LIGHT_W-1:0] light;
  } s1_t;

endpackage

// ===== sv/tws_ifs.sv =====
// valid/ready channel interfaces for draw/write items and shaded pixels
interface tws_in_if import tws_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            operation;
  logic [COL_W-1:0]           column_x;
  logic signed [ROW_W-1:0]    top_row;
  logic [WALL_W-1:0]          tex_height;
  logic [SCALED_W-1:0]        span_height;
  logic [LINE_W-1:0]          texture_line;
  logic [CLIP_W-1:0]          clip_top;
  logic [CLIP_W-1:0]          clip_bot;
  logic [IDX_W-1:0]           texel_index;
  logic [TEXEL_W-1:0]         texel_value;

  modport source (
    output valid, operation, column_x, top_row, tex_height, span_height,
           texture_line, clip_top, clip_bot, texel_index, texel_value,
    input  ready
  );
  modport sink (
    input  valid, operation, column_x, top_row, tex_height, span_height,
           texture_line, clip_top, clip_bot, texel_index, texel_value,
    output ready
  );
endinterface

interface tws_out_if import tws_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COL_W-1:0]   pixel_x;
  logic [PY_W-1:0]    pixel_y;
  logic [TEXEL_W-1:0] pixel_color;
  logic               last;

  modport source (output valid, pixel_x, pixel_y, pixel_color, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pixel_color, last, output ready);
endinterface

// ===== sv/textured_wall_column_shader.sv =====
// textured wall column shader: texel memory, step/light dividers and pixel walk
//
// Usage: in_item carries write items (operation 0: one texel into the texture
// memory) and draw items (operation 1: one wall column). out_pix returns one
// shaded RGB565 pixel item per drawn row, top to bottom, with last set on the
// final row of the column. Both channels use valid/ready.
// A write item stores its texel when accepted, if its line and index lie
// inside the texture. A draw item runs a bit-serial divide for the texture
// step (the 5-bit light quotient is formed at its start), a clip multiply and
// a clip add, then issues one texel read per cycle, while out_pix takes pixels,
// from the texture memory read port; each pixel passes the read and the output
// register. The block is busy until the bottom row is read; the next item is
// then taken while the column still drains. An empty draw is dropped at accept.
// When out_pix stalls, the read stage still fills, then no new texel is read.
// Reset (rst_n low, synchronous) returns the control to idle and drops
// pending pixels; the texture memory keeps no reset value and needs no
// clearing pass, texels must be written before they are drawn.
module textured_wall_column_shader import tws_pkg::*; #(
  parameter int unsigned TEX_SIZE = TEX_SIZE_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  tws_in_if.sink    in_item,
  tws_out_if.source out_pix
);

  localparam int unsigned DEPTH     = TEX_SIZE * TEX_SIZE;
  localparam int          AW        = $clog2(DEPTH);
  localparam int          TIW       = $clog2(TEX_SIZE);
  localparam int          DIV_STEPS = STEP_W;
  localparam int          CNT_W     = $clog2(DIV_STEPS);
  localparam int          SW        = ROW_W + 1;

  // control states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_CLIP = 3'd3;
  localparam logic [2:0] S_RUN  = 3'd4;

  function automatic logic [TEXEL_W-1:0] shade(input logic [TEXEL_W-1:0] c,
                                               input logic [LIGHT_W-1:0] lt);
    logic [10:0] rp;
    logic [11:0] gp;
    logic [10:0] bp;
    rp = 11'(c[15:11]) * 11'(lt);
    gp = 12'(c[10:5]) * 12'(lt);
    bp = 11'(c[4:0]) * 11'(lt);
    return {rp[9:5], gp[10:5], bp[9:5]};
  endfunction

  logic [2:0]            state_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [STEP_W-1:0]     quo_r;
  logic [SCALED_W-1:0]   rem_r;
  logic [SCALED_W-1:0]   scaled_r;
  logic [WALL_W-1:0]     wall_r;
  logic [WALL_W-1:0]     lrem_r;
  logic [LQ_W-1:0]       lq_r;
  logic                  lsat_r;
  logic [ROW_W-1:0]      clip_r;
  logic [POS_W-1:0]      prod_r;
  logic [POS_W-1:0]      pos_r;
  logic [COL_W-1:0]      col_r;
  logic [LINE_W-1:0]     line_r;
  logic                  line_ok_r;
  logic [PY_W-1:0]       y_r;
  logic [PY_W-1:0]       bot_r;
  logic                  s1_v_r;
  s1_t                   s1_r;
  logic [TEXEL_W-1:0]    rd_data_r;
  logic                  out_v_r;
  logic [COL_W-1:0]      out_x_r;
  logic [PY_W-1:0]       out_y_r;
  logic [TEXEL_W-1:0]    out_c_r;
  logic                  out_last_r;

  logic [TEXEL_W-1:0]    tex_mem [DEPTH];

  // handshakes
  logic in_acc, draw_acc, mem_we, rd_en, out_load;
  assign in_item.ready = (state_r == S_IDLE);
  assign in_acc   = in_item.valid && in_item.ready;
  assign out_load = s1_v_r && (!out_v_r || out_pix.ready);
  assign rd_en    = (state_r == S_RUN) && (!s1_v_r || out_load);

  // clipping of the span at accept time
  logic signed [SW-1:0] top_s, sum_s, uclip_s, lclip_s, rmax_s, bot_a, bot_s, y_s;
  logic                 top_above, empty;
  logic [ROW_W-1:0]     clip_dist;
  logic [POS_W-1:0]     wall_w, pos_diff;
  assign top_s     = SW'(in_item.top_row);
  assign sum_s     = top_s + $signed({2'b00, in_item.span_height});
  assign uclip_s   = $signed({{(SW-CLIP_W){1'b0}}, in_item.clip_top});
  assign lclip_s   = $signed({{(SW-CLIP_W){1'b0}}, in_item.clip_bot});
  assign rmax_s    = SW'(SCREEN_ROWS - 1);
  assign bot_a     = (sum_s > lclip_s) ? lclip_s : sum_s;
  assign bot_s     = (bot_a > rmax_s) ? rmax_s : bot_a;
  assign top_above = (top_s < uclip_s);
  assign y_s       = top_above ? uclip_s : top_s;
  assign empty     = (in_item.span_height == '0) || (bot_s < y_s);
  assign clip_dist = top_above ? ROW_W'(uclip_s - top_s) : '0;
  assign wall_w    = POS_W'(in_item.tex_height);
  assign pos_diff  = (wall_w > TEX_SIZE) ? (wall_w - TEX_SIZE) : (TEX_SIZE - wall_w);
  assign draw_acc  = in_acc && (in_item.operation == OP_DRAW) && !empty;

  // texel write address
  logic [AW-1:0] wr_addr;
  logic          wr_ok;
  assign wr_ok   = (32'(in_item.texture_line) < TEX_SIZE) &&
                   (32'(in_item.texel_index) < TEX_SIZE);
  assign wr_addr = AW'(32'(in_item.texture_line) * TEX_SIZE + 32'(in_item.texel_index));
  assign mem_we  = in_acc && (in_item.operation == OP_WRITE) && wr_ok;

  // step divider: one quotient bit per cycle
  logic [SCALED_W:0]   rem_sh, rem_dif;
  logic                q_bit;
  logic [SCALED_W-1:0] rem_nxt;
  assign rem_sh  = {rem_r, quo_r[STEP_W-1]};
  assign rem_dif = rem_sh - {1'b0, scaled_r};
  assign q_bit   = (rem_sh >= {1'b0, scaled_r});
  assign rem_nxt = q_bit ? rem_dif[SCALED_W-1:0] : rem_sh[SCALED_W-1:0];

  // light divider: scaled*32/wall when scaled is below wall
  logic [WALL_W:0]   lrem_sh, lrem_dif;
  logic              lq_bit;
  logic [WALL_W-1:0] lrem_nxt;
  assign lrem_sh  = {lrem_r, 1'b0};
  assign lrem_dif = lrem_sh - {1'b0, wall_r};
  assign lq_bit   = (lrem_sh >= {1'b0, wall_r});
  assign lrem_nxt = lq_bit ? lrem_dif[WALL_W-1:0] : lrem_sh[WALL_W-1:0];

  logic [LIGHT_W-1:0] light_w;
  assign light_w = lsat_r ? LIGHT_W'(LIGHT_MAX) : {1'b0, lq_r};

  // texel read address from the walk position
  logic [TIW-1:0] ti;
  logic [AW-1:0]  rd_addr;
  assign ti      = pos_r[FRAC_W +: TIW] & TIW'(TEX_SIZE - 1);
  assign rd_addr = line_ok_r ? AW'(32'(line_r) * TEX_SIZE + 32'(ti)) : '0;

  // texture memory, synchronous read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tex_mem[wr_addr] <= in_item.texel_value;
    end
    if (rd_en) begin
      rd_data_r <= tex_mem[rd_addr];
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      case (state_r)
        S_IDLE: if (draw_acc) state_r <= S_DIV;
        S_DIV:  if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_r <= S_MUL;
        S_MUL:  state_r <= S_CLIP;
        S_CLIP: state_r <= S_RUN;
        S_RUN:  if (rd_en && (y_r == bot_r)) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // column datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (draw_acc) begin
          cnt_r     <= '0;
          quo_r     <= {in_item.tex_height, {FRAC_W{1'b0}}};
          rem_r     <= '0;
          scaled_r  <= in_item.span_height;
          wall_r    <= in_item.tex_height;
          lrem_r    <= in_item.span_height[WALL_W-1:0];
          lq_r      <= '0;
          lsat_r    <= (15'(in_item.tex_height) <= in_item.span_height);
          clip_r    <= clip_dist;
          pos_r     <= pos_diff << FRAC_W;
          col_r     <= in_item.column_x;
          line_r    <= in_item.texture_line;
          line_ok_r <= (32'(in_item.texture_line) < TEX_SIZE);
          y_r       <= PY_W'(y_s);
          bot_r     <= PY_W'(bot_s);
        end
      end
      S_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        quo_r <= {quo_r[STEP_W-2:0], q_bit};
        rem_r <= rem_nxt;
        if (cnt_r < CNT_W'(LQ_W)) begin
          lrem_r <= lrem_nxt;
          lq_r   <= {lq_r[LQ_W-2:0], lq_bit};
        end
      end
      S_MUL: begin
        prod_r <= POS_W'(quo_r) * POS_W'(clip_r);
      end
      S_CLIP: begin
        pos_r <= pos_r + prod_r;
      end
      S_RUN: begin
        if (rd_en) begin
          pos_r <= pos_r + POS_W'(quo_r);
          y_r   <= y_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // read stage and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rd_en) begin
        s1_v_r <= 1'b1;
      end else if (out_load) begin
        s1_v_r <= 1'b0;
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_pix.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      s1_r.col     <= col_r;
      s1_r.y       <= y_r;
      s1_r.last    <= (y_r == bot_r);
      s1_r.line_ok <= line_ok_r;
      s1_r.light   <= light_w;
    end
    if (out_load) begin
      out_x_r    <= s1_r.col;
      out_y_r    <= s1_r.y;
      out_last_r <= s1_r.last;
      out_c_r    <= shade(s1_r.line_ok ? rd_data_r : '0, s1_r.light);
    end
  end

  assign out_pix.valid       = out_v_r;
  assign out_pix.pixel_x     = out_x_r;
  assign out_pix.pixel_y     = out_y_r;
  assign out_pix.pixel_color = out_c_r;
  assign out_pix.last        = out_last_r;

`ifndef SYNTHESIS
  // the walk never passes the clipped bottom row
  a_run_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (y_r <= bot_r))
    else $error("row walk passed the bottom row");

  // issuing the bottom row ends the column
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && (y_r == bot_r)) |=> (state_r == S_IDLE))
    else $error("column did not end after its last row");

  // divide counter stays within its step count
  a_div_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (cnt_r < CNT_W'(DIV_STEPS)))
    else $error("divide counter overran");

  // light carried with a pixel never exceeds full brightness
  a_light_max: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> (s1_r.light <= LIGHT_W'(LIGHT_MAX)))
    else $error("light above full brightness");
`endif

endmodule

// ===== tb/tb_textured_wall_column_shader.sv =====
// self-checking testbench for the textured wall column shader
module tb_textured_wall_column_shader;
  import tws_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT = 800000;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_WAIT  = 100;
  localparam int          MAX_REPORTS = 40;
  localparam bit [31:0]   TEX_SZ      = TEX_SIZE_DEF;
  // random draws use a few texture lines so the texel preload stays short
  localparam int          DRAW_LINES  = 2;

  // one input item, write or draw
  typedef struct {
    bit [OP_W-1:0]            op;
    bit [COL_W-1:0]           col;
    bit signed [ROW_W-1:0]    top;
    bit [WALL_W-1:0]          wall;
    bit [SCALED_W-1:0]        scaled;
    bit [LINE_W-1:0]          line;
    bit [CLIP_W-1:0]          uclip;
    bit [CLIP_W-1:0]          lclip;
    bit [IDX_W-1:0]           idx;
    bit [TEXEL_W-1:0]         value;
  } wall_item_t;

  // one shaded pixel, with the texel position it was read from
  typedef struct {
    bit [COL_W-1:0]   col;
    bit [PY_W-1:0]    row;
    bit [TEXEL_W-1:0] color;
    bit               last;
    bit [IDX_W-1:0]   tex_idx;
  } pixel_t;

  logic clk;
  logic rst_n;

  tws_in_if  in_if ();
  tws_out_if out_if ();

  textured_wall_column_shader u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_item (in_if),
    .out_pix (out_if)
  );

  // texture copy and pixels still owed by the block
  bit [TEXEL_W-1:0] texels [0:4095];
  bit               texel_written [0:4095];
  pixel_t           pending_pixels [$];

  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_left   = 0;
  int unsigned stall_left  = 0;
  logic        idle_on     = 1'b1;
  logic        hold_request = 1'b0;

  // 100 MHz clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // darken one rgb565 texel per channel
  function automatic bit [TEXEL_W-1:0] dim_texel(bit [TEXEL_W-1:0] c, bit [5:0] light);
    bit [10:0] r, g, b;
    r = (11'(c[15:11]) * 11'(light)) >> 5;
    g = (11'(c[10:5]) * 11'(light)) >> 5;
    b = (11'(c[4:0]) * 11'(light)) >> 5;
    return {r[4:0], g[5:0], b[4:0]};
  endfunction

  // pixels of one draw item, shaded from the current texture copy
  function automatic void walk_column(input wall_item_t it, ref pixel_t px[$]);
    bit [31:0] step, pos, light, wall32, scaled32;
    int        top, bottom, y;
    pixel_t    p;
    px.delete();
    if (it.scaled == 0) return;
    wall32   = 32'(it.wall);
    scaled32 = 32'(it.scaled);
    step     = (wall32 << 16) / scaled32;
    if (it.wall == 0) light = 32;
    else light = (scaled32 * 32) / wall32;
    if (light > 32) light = 32;
    pos = ((wall32 > TEX_SZ) ? wall32 - TEX_SZ : TEX_SZ - wall32) << 16;
    top    = int'(it.top);
    bottom = top + int'(scaled32);
    if (bottom > int'(it.lclip)) bottom = int'(it.lclip);
    if (bottom > SCREEN_ROWS - 1) bottom = SCREEN_ROWS - 1;
    y = top;
    // top clipping advances the walk, wrapping at 32 bits
    if (y < int'(it.uclip)) begin
      pos = pos + step * 32'(int'(it.uclip) - y);
      y   = int'(it.uclip);
    end
    for (; y <= bottom; y++) begin
      p.tex_idx = pos[21:16];
      p.col     = it.col;
      p.row     = y[5:0];
      p.last    = (y == bottom);
      p.color   = dim_texel(texels[{it.line, p.tex_idx}], light[5:0]);
      px.push_back(p);
      pos = pos + step;
    end
  endfunction

  function automatic wall_item_t random_fields();
    wall_item_t it;
    it.op     = OP_W'($urandom);
    it.col    = COL_W'($urandom);
    it.top    = ROW_W'($urandom);
    it.wall   = WALL_W'($urandom);
    it.scaled = SCALED_W'($urandom);
    it.line   = LINE_W'($urandom);
    it.uclip  = CLIP_W'($urandom);
    it.lclip  = CLIP_W'($urandom);
    it.idx    = IDX_W'($urandom);
    it.value  = TEXEL_W'($urandom);
    return it;
  endfunction

  function automatic wall_item_t make_texel(int line, int idx, int value);
    wall_item_t it;
    it       = random_fields();
    it.op    = OP_WRITE;
    it.line  = LINE_W'(line);
    it.idx   = IDX_W'(idx);
    it.value = TEXEL_W'(value);
    return it;
  endfunction

  function automatic wall_item_t make_column(int col, int top, int wall, int scaled,
                                             int line, int uclip, int lclip);
    wall_item_t it;
    it        = random_fields();
    it.op     = OP_DRAW;
    it.col    = COL_W'(col);
    it.top    = ROW_W'(top);
    it.wall   = WALL_W'(wall);
    it.scaled = SCALED_W'(scaled);
    it.line   = LINE_W'(line);
    it.uclip  = CLIP_W'(uclip);
    it.lclip  = CLIP_W'(lclip);
    return it;
  endfunction

  // a column that usually lands on screen, random content
  function automatic wall_item_t sane_column();
    wall_item_t it;
    it        = random_fields();
    it.op     = OP_DRAW;
    it.top    = ROW_W'($urandom_range(0, 90) - 20);
    it.wall   = WALL_W'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 4095)
                                                     : $urandom_range(1, 160));
    it.scaled = SCALED_W'($urandom_range(1, 100));
    it.line   = LINE_W'($urandom_range(0, DRAW_LINES - 1));
    it.uclip  = CLIP_W'($urandom_range(0, 20));
    it.lclip  = CLIP_W'($urandom_range(30, 63));
    return it;
  endfunction

  // offer one item, update the texture copy or queue pixels once accepted
  task automatic send_item(input wall_item_t it);
    pixel_t px[$];
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.operation     <= it.op;
    in_if.column_x      <= it.col;
    in_if.top_row       <= it.top;
    in_if.tex_height    <= it.wall;
    in_if.span_height   <= it.scaled;
    in_if.texture_line  <= it.line;
    in_if.clip_top      <= it.uclip;
    in_if.clip_bot      <= it.lclip;
    in_if.texel_index   <= it.idx;
    in_if.texel_value   <= it.value;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    if (it.op == OP_WRITE) begin
      texels[{it.line, it.idx}]        = it.value;
      texel_written[{it.line, it.idx}] = 1'b1;
    end else begin
      walk_column(it, px);
      foreach (px[i]) pending_pixels.push_back(px[i]);
    end
  endtask

  // load every texel the column will read before drawing it
  task automatic draw_column(input wall_item_t it);
    pixel_t px[$];
    walk_column(it, px);
    foreach (px[i]) begin
      if (!texel_written[{it.line, px[i].tex_idx}])
        send_item(make_texel(int'(it.line), int'(px[i].tex_idx),
                             int'($urandom_range(0, 65535))));
    end
    send_item(it);
  endtask

  // sender pauses until the block has returned every pixel
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  // extreme texel values and positions
  task automatic test_texel_writes();
    send_item(make_texel(0, 0, 16'hffff));
    send_item(make_texel(63, 63, 16'h0000));
    send_item(make_texel(21, 42, 16'haaaa));
    send_item(make_texel(42, 21, 16'h5555));
    wait_drained();
  endtask

  // field extremes and the corner cases of the column walk
  task automatic test_directed_columns();
    draw_column(make_column(0, 0, 64, 64, 0, 0, 63));             // full height
    draw_column(make_column(1023, 0, 0, 40, 63, 0, 63));          // zero wall height
    draw_column(make_column(5, 10, 4095, 1, 1, 0, 63));           // light drops to zero
    draw_column(make_column(7, 3, 32, 0, 2, 0, 63));              // zero scaled height
    draw_column(make_column(9, 20, 64, 30, 3, 30, 10));           // clip rows crossed
    draw_column(make_column(11, -100, 100, 32767, 4, 0, 63));     // long top clip
    draw_column(make_column(13, -32768, 4095, 32767, 5, 63, 63)); // ends above screen
    draw_column(make_column(15, 32767, 64, 32767, 6, 0, 63));     // starts below screen
    draw_column(make_column(17, 63, 64, 10, 7, 63, 63));          // single bottom row
    draw_column(make_column(19, -5, 200, 50, 8, 2, 40));          // both clips, dimmed
    draw_column(make_column(21, 0, 1, 63, 9, 0, 63));             // small step, full light
    draw_column(make_column(23, 0, 64, 64, 10, 63, 0));           // empty clip window
    wait_drained();
  endtask

  // receiver holds off while full columns keep coming
  task automatic test_output_hold();
    hold_request <= 1'b1;
    repeat (8) draw_column(make_column($urandom_range(0, 1023), 0, 64, 64,
                                       $urandom_range(0, DRAW_LINES - 1), 0, 63));
    wait_drained();
  endtask

  // mostly on-screen columns, some writes, noise and broken columns
  task automatic run_random_items(input int count);
    wall_item_t it;
    int         pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        draw_column(sane_column());
      end else if (pick < 70) begin
        it      = random_fields();
        it.op   = OP_DRAW;
        it.line = LINE_W'($urandom_range(0, DRAW_LINES - 1));
        draw_column(it);
      end else if (pick < 75) begin
        it = sane_column();
        if ($urandom_range(0, 1) == 0) it.scaled = '0;
        else begin
          it.uclip = CLIP_W'($urandom_range(32, 63));
          it.lclip = CLIP_W'($urandom_range(0, 31));
        end
        draw_column(it);
      end else begin
        it    = random_fields();
        it.op = OP_WRITE;
        send_item(it);
      end
      if ($urandom_range(0, 49) == 0) wait_drained();
    end
  endtask

  task automatic test_random_mix();
    run_random_items(210);
    wait_drained();
  endtask

  // back to back with no idling on either side
  task automatic test_streaming();
    idle_on <= 1'b0;
    @(posedge clk);
    run_random_items(40);
    wait_drained();
  endtask

  // result side: ready with random stalls and the long hold-off
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = HOLD_CYCLES;
      hold_request <= 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 5) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  function automatic void report_field(string field, int unsigned want, int unsigned got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
  endfunction

  // compare each pixel with the oldest one owed
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d color=0x%0h",
                   $time, out_if.pixel_x, out_if.pixel_y, out_if.pixel_color);
      end else begin
        want = pending_pixels.pop_front();
        if (out_if.pixel_x !== want.col)
          report_field("pixel_x", 32'(want.col), 32'(out_if.pixel_x));
        if (out_if.pixel_y !== want.row)
          report_field("pixel_y", 32'(want.row), 32'(out_if.pixel_y));
        if (out_if.pixel_color !== want.color)
          report_field("pixel_color", 32'(want.color), 32'(out_if.pixel_color));
        if (out_if.last !== want.last)
          report_field("last", 32'(want.last), 32'(out_if.last));
      end
    end
  end

  // reset, then the tests in turn
  initial begin
    rst_n               = 1'b0;
    in_if.valid         = 1'b0;
    in_if.operation     = OP_WRITE;
    in_if.column_x      = '0;
    in_if.top_row       = '0;
    in_if.tex_height    = '0;
    in_if.span_height   = '0;
    in_if.texture_line  = '0;
    in_if.clip_top      = '0;
    in_if.clip_bot      = '0;
    in_if.texel_index   = '0;
    in_if.texel_value   = '0;
    out_if.ready        = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_texel_writes();
    test_directed_columns();
    test_output_hold();
    test_random_mix();
    test_streaming();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/tws_pkg.sv
sv/tws_ifs.sv
sv/textured_wall_column_shader.sv
tb/tb_textured_wall_column_shader.sv
